// ===== rtl/cpa_pkg.sv =====
// ---------------------------------------------------------------------------
// cpa_pkg: shared types and constants of the command priority array
// Sizes of the object and slot stores, field widths, status and operation
// codes, and the slot priority encoder.
// ---------------------------------------------------------------------------
package cpa_pkg;

   // Store sizes.
   localparam int NUM_OBJECTS    = 8;
   localparam int NUM_PRIORITIES = 16;
   localparam int OBJ_W  = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
   localparam int SLOT_W = $clog2(NUM_PRIORITIES);
   localparam int VAL_DEPTH = NUM_OBJECTS * (1 << SLOT_W);
   localparam int VAL_AW    = OBJ_W + SLOT_W;

   // Field widths.
   localparam int OP_W    = 2;
   localparam int INDEX_W = 8;
   localparam int PRIO_W  = 5;
   localparam int LEVEL_W = 8;
   localparam int STAT_W  = 3;
   localparam int PV_W    = 7;

   // Level limits and the reserved slot.
   localparam int MAX_LEVEL         = 100;
   localparam int RESERVED_PRIORITY = 6;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WRITE      = 2'd0;
   localparam logic [OP_W-1:0] OP_RELINQUISH = 2'd1;
   localparam logic [OP_W-1:0] OP_READ       = 2'd2;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK             = 3'd0;
   localparam logic [STAT_W-1:0] ST_UNKNOWN_OBJECT = 3'd1;
   localparam logic [STAT_W-1:0] ST_ACCESS_DENIED  = 3'd2;
   localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE   = 3'd3;
   localparam logic [STAT_W-1:0] ST_BAD_INDEX      = 3'd4;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_MASK,
      S_VALUE
   } state_type;

   // One captured input item.
   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [INDEX_W-1:0] object_id;
      logic [PRIO_W-1:0]  priority_req;
      logic [LEVEL_W-1:0] level;
   } item_type;

   // Outcome of the mask update, handed to the value stage.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              any;
      logic [SLOT_W-1:0] win;
      logic              fwd;
      logic [PV_W-1:0]   slot_level;
      logic              slot_null;
   } update_type;

   // Lowest-numbered occupied slot of a mask (slot 0 is priority 1).
   function automatic logic [SLOT_W-1:0] first_set(input logic [NUM_PRIORITIES-1:0] m);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = SLOT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== rtl/cpa_if.sv =====
// ---------------------------------------------------------------------------
// cpa_if: channel interfaces of the command priority array
// Request, response and register write channels, each with valid and ready.
// ---------------------------------------------------------------------------
interface cpa_req_if import cpa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [INDEX_W-1:0] object_id;
   logic [PRIO_W-1:0]  priority_req;
   logic [LEVEL_W-1:0] level;

   modport source (output valid, output operation, output object_id,
                   output priority_req, output level, input ready);
   modport sink   (input valid, input operation, input object_id,
                   input priority_req, input level, output ready);
endinterface

interface cpa_rsp_if import cpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [PV_W-1:0]   present_value;
   logic [PRIO_W-1:0] active_priority;
   logic [PV_W-1:0]   slot_level;
   logic              slot_null;

   modport source (output valid, output status, output present_value,
                   output active_priority, output slot_level, output slot_null,
                   input ready);
   modport sink   (input valid, input status, input present_value,
                   input active_priority, input slot_level, input slot_null,
                   output ready);
endinterface

interface cpa_csr_if import cpa_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [PV_W-1:0] relinquish_default;

   modport source (output valid, output relinquish_default, input ready);
   modport sink   (input valid, input relinquish_default, output ready);
endinterface

// ===== rtl/cpa_ram.sv =====
// ---------------------------------------------------------------------------
// cpa_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ---------------------------------------------------------------------------
module cpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/command_priority_array.sv =====
// ---------------------------------------------------------------------------
// command_priority_array: 16-slot command priority array per output object
// The value stage loads the response register after the mask stage; a held
// response stalls it. A new item is taken only back in idle; the mask read,
// the mask update and the winner-level read share one read port on each store.
// The response register frees the request side while a result waits.
// Reset clears the occupancy valid bits and the relinquish default at once;
// no clearing pass is needed.
// ---------------------------------------------------------------------------
module command_priority_array import cpa_pkg::*; (
   input logic       clock,
   input logic       reset,
   cpa_req_if.sink   req_bus,
   cpa_rsp_if.source rsp_bus,
   cpa_csr_if.sink   csr_bus
);

   state_type state_ff, state_in;
   item_type  item_ff, item_in;
   update_type upd_ff, upd_in;

   logic [PV_W-1:0]        default_ff, default_in;
   logic [NUM_OBJECTS-1:0] mask_valid_ff, mask_valid_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PV_W-1:0]   rsp_pv_ff, rsp_pv_in;
   logic [PRIO_W-1:0] rsp_ap_ff, rsp_ap_in;
   logic [PV_W-1:0]   rsp_slot_level_ff, rsp_slot_level_in;
   logic              rsp_slot_null_ff, rsp_slot_null_in;

   // Memory ports.
   logic                      mask_we;
   logic [OBJ_W-1:0]          mask_rd_addr;
   logic [NUM_PRIORITIES-1:0] mask_rd_data;
   logic [NUM_PRIORITIES-1:0] new_mask;
   logic                      val_we;
   logic [VAL_AW-1:0]         val_wr_addr;
   logic [VAL_AW-1:0]         val_rd_addr;
   logic [PV_W-1:0]           val_rd_data;

   // Decode of the captured item.
   logic [OBJ_W-1:0]          obj;
   logic [SLOT_W-1:0]         bit_idx;
   logic                      known;
   logic                      prio_ok;
   logic [NUM_PRIORITIES-1:0] old_mask;
   logic [NUM_PRIORITIES-1:0] slot_sel;
   logic                      out_free;
   logic [PV_W-1:0]           default_level;
   logic                      req_fire;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Register write port; the default is clamped to full level on use.
   assign csr_bus.ready = 1'b1;
   assign default_in    = (csr_bus.valid) ? csr_bus.relinquish_default : default_ff;
   assign default_level = (default_ff > PV_W'(MAX_LEVEL)) ? PV_W'(MAX_LEVEL) : default_ff;

   // Item decode from the captured fields.
   assign obj      = item_ff.object_id[OBJ_W-1:0];
   assign bit_idx  = SLOT_W'(item_ff.priority_req - PRIO_W'(1));
   assign known    = ({1'b0, item_ff.object_id} < (INDEX_W + 1)'(NUM_OBJECTS));
   assign prio_ok  = (item_ff.priority_req >= PRIO_W'(1)) &&
                     (item_ff.priority_req <= PRIO_W'(NUM_PRIORITIES));
   assign old_mask = (mask_valid_ff[obj]) ? mask_rd_data : '0;
   assign slot_sel = NUM_PRIORITIES'(1) << bit_idx;

   // Occupancy masks, one row per object.
   cpa_ram #(
      .WIDTH (NUM_PRIORITIES),
      .DEPTH (1 << OBJ_W)
   ) u_mask_ram (
      .clock   (clock),
      .we      (mask_we),
      .wr_addr (obj),
      .wr_data (new_mask),
      .rd_addr (mask_rd_addr),
      .rd_data (mask_rd_data)
   );

   // Slot levels, addressed by object and slot.
   cpa_ram #(
      .WIDTH (PV_W),
      .DEPTH (VAL_DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .we      (val_we),
      .wr_addr (val_wr_addr),
      .wr_data (item_ff.level[PV_W-1:0]),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   assign val_wr_addr = {obj, bit_idx};

   // Sequencer: capture, update the mask, then read the winning level.
   always_comb begin
      state_in          = state_ff;
      item_in           = item_ff;
      upd_in            = upd_ff;
      mask_valid_in     = mask_valid_ff;
      mask_we           = 1'b0;
      val_we            = 1'b0;
      new_mask          = old_mask;
      mask_rd_addr      = req_bus.object_id[OBJ_W-1:0];
      val_rd_addr       = {obj, upd_ff.win};
      req_bus.ready     = (state_ff == S_IDLE);
      rsp_valid_in      = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in     = rsp_status_ff;
      rsp_pv_in         = rsp_pv_ff;
      rsp_ap_in         = rsp_ap_ff;
      rsp_slot_level_in = rsp_slot_level_ff;
      rsp_slot_null_in  = rsp_slot_null_ff;

      unique case (state_ff)
         S_IDLE: begin
            // Read the mask row and the addressed slot of the new item.
            val_rd_addr = {req_bus.object_id[OBJ_W-1:0],
                           SLOT_W'(req_bus.priority_req - PRIO_W'(1))};
            if (req_fire) begin
               item_in.operation    = req_bus.operation;
               item_in.object_id    = req_bus.object_id;
               item_in.priority_req = req_bus.priority_req;
               item_in.level        = req_bus.level;
               state_in             = S_MASK;
            end
         end
         S_MASK: begin
            // Check the item and pick the status.
            upd_in.status = ST_OK;
            priority if (!known) begin
               upd_in.status = ST_UNKNOWN_OBJECT;
            end else if (item_ff.operation == OP_WRITE ||
                         item_ff.operation == OP_RELINQUISH) begin
               priority if (item_ff.priority_req == PRIO_W'(RESERVED_PRIORITY)) begin
                  upd_in.status = ST_ACCESS_DENIED;
               end else if (!prio_ok || (item_ff.operation == OP_WRITE &&
                            item_ff.level > LEVEL_W'(MAX_LEVEL))) begin
                  upd_in.status = ST_OUT_OF_RANGE;
               end else if (item_ff.operation == OP_WRITE) begin
                  new_mask = old_mask | slot_sel;
                  val_we   = 1'b1;
               end else begin
                  new_mask = old_mask & ~slot_sel;
               end
            end else if (item_ff.operation == OP_READ) begin
               if (!prio_ok) begin
                  upd_in.status = ST_BAD_INDEX;
               end
            end else begin
               upd_in.status = ST_ACCESS_DENIED;
            end

            // Slot read result from the old mask and the slot level.
            upd_in.slot_level = '0;
            upd_in.slot_null  = 1'b0;
            if (known && item_ff.operation == OP_READ && prio_ok) begin
               if (old_mask[bit_idx]) begin
                  upd_in.slot_level = val_rd_data;
               end else begin
                  upd_in.slot_null = 1'b1;
               end
            end

            // Write the row back and look up the winning slot.
            mask_we = known;
            if (known) begin
               mask_valid_in[obj] = 1'b1;
            end
            upd_in.win  = first_set(new_mask);
            upd_in.any  = known && (|new_mask);
            upd_in.fwd  = val_we && (first_set(new_mask) == bit_idx);
            val_rd_addr = {obj, first_set(new_mask)};
            state_in    = S_VALUE;
         end
         S_VALUE: begin
            // Load the response register once it is free.
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = upd_ff.status;
               rsp_slot_level_in = upd_ff.slot_level;
               rsp_slot_null_in  = upd_ff.slot_null;
               if (upd_ff.any) begin
                  rsp_pv_in = (upd_ff.fwd) ? item_ff.level[PV_W-1:0] : val_rd_data;
                  rsp_ap_in = PRIO_W'({1'b0, upd_ff.win}) + PRIO_W'(1);
               end else begin
                  rsp_pv_in = default_level;
                  rsp_ap_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mask_valid_ff <= '0;
         default_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mask_valid_ff <= mask_valid_in;
         default_ff    <= default_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff           <= item_in;
      upd_ff            <= upd_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_pv_ff         <= rsp_pv_in;
      rsp_ap_ff         <= rsp_ap_in;
      rsp_slot_level_ff <= rsp_slot_level_in;
      rsp_slot_null_ff  <= rsp_slot_null_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.present_value   = rsp_pv_ff;
   assign rsp_bus.active_priority = rsp_ap_ff;
   assign rsp_bus.slot_level      = rsp_slot_level_ff;
   assign rsp_bus.slot_null       = rsp_slot_null_ff;

   // An accepted item always moves on to the mask update.
   a_accept_to_mask: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_MASK)
      else $error("accepted item did not enter the mask update");

   // The value stage loads the response and returns to idle once the output is free.
   a_rsp_from_value: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VALUE && out_free) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("value stage did not load the response");

   // The winning priority never exceeds the slot count.
   a_ap_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ap_ff <= PRIO_W'(NUM_PRIORITIES))
      else $error("active priority out of range");

   // An unknown object reports no winner and no slot data.
   a_unknown_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_UNKNOWN_OBJECT) |->
         (rsp_ap_ff == '0 && rsp_slot_null_ff == 1'b0 && rsp_slot_level_ff == '0))
      else $error("unknown object response carries slot data");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for command_priority_array
// Drives command items through the request channel with random gaps, takes
// responses with random stalls and one long hold-off, and compares each
// response with a priority array kept alongside the block. The relinquish
// default is rewritten between phases, including values above 100.
// ---------------------------------------------------------------------------
module tb;
   import cpa_pkg::*;

   // Operation code with no action in the block.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 6;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int REPORT_LIMIT = 10;

   // One response item, field by field.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PV_W-1:0]   present_value;
      logic [PRIO_W-1:0] active_priority;
      logic [PV_W-1:0]   slot_level;
      logic              slot_null;
   } response_type;

   // Priority array state and the queue of responses still to arrive.
   class priority_array_scoreboard;
      logic [PV_W-1:0]           slot_levels [NUM_OBJECTS][NUM_PRIORITIES];
      logic [NUM_PRIORITIES-1:0] slot_occupied [NUM_OBJECTS];
      logic [PV_W-1:0]           default_level;
      response_type              pending_responses[$];
      int                        mismatches;
      int                        responses_checked;
      int                        status_counts [8];

      function new();
         foreach (slot_occupied[o]) begin
            slot_occupied[o] = '0;
            foreach (slot_levels[o][p]) begin
               slot_levels[o][p] = '0;
            end
         end
         foreach (status_counts[s]) begin
            status_counts[s] = 0;
         end
         default_level = '0;
         mismatches = 0;
         responses_checked = 0;
      endfunction

      function void set_default(input logic [PV_W-1:0] value);
         default_level = value;
      endfunction

      function int pending();
         return pending_responses.size();
      endfunction

      // Applies one command to the array and returns the response it causes.
      function response_type resolve_command(input logic [OP_W-1:0] op,
                                             input logic [INDEX_W-1:0] obj,
                                             input logic [PRIO_W-1:0] prio,
                                             input logic [LEVEL_W-1:0] lvl);
         response_type r;
         logic         prio_ok;
         logic         found;
         int           o;
         int           slot;
         r = '0;
         r.present_value = (default_level > MAX_LEVEL) ? PV_W'(MAX_LEVEL) : default_level;
         prio_ok = (prio >= 1) && (prio <= NUM_PRIORITIES);
         o = obj;
         slot = int'(prio) - 1;
         if (obj >= NUM_OBJECTS) begin
            r.status = ST_UNKNOWN_OBJECT;
         end else begin
            case (op)
               OP_WRITE, OP_RELINQUISH: begin
                  if (prio == RESERVED_PRIORITY) begin
                     r.status = ST_ACCESS_DENIED;
                  end else if (!prio_ok || (op == OP_WRITE && lvl > MAX_LEVEL)) begin
                     r.status = ST_OUT_OF_RANGE;
                  end else if (op == OP_WRITE) begin
                     slot_levels[o][slot] = lvl[PV_W-1:0];
                     slot_occupied[o][slot] = 1'b1;
                  end else begin
                     slot_occupied[o][slot] = 1'b0;
                  end
               end
               OP_READ: begin
                  if (!prio_ok) begin
                     r.status = ST_BAD_INDEX;
                  end else if (slot_occupied[o][slot]) begin
                     r.slot_level = slot_levels[o][slot];
                  end else begin
                     r.slot_null = 1'b1;
                  end
               end
               default: begin
                  r.status = ST_ACCESS_DENIED;
               end
            endcase
            // The lowest-numbered occupied slot wins.
            found = 1'b0;
            for (int i = 0; i < NUM_PRIORITIES; i++) begin
               if (!found && slot_occupied[o][i]) begin
                  found = 1'b1;
                  r.present_value = slot_levels[o][i];
                  r.active_priority = PRIO_W'(i + 1);
               end
            end
         end
         return r;
      endfunction

      function void note_command(input logic [OP_W-1:0] op,
                                 input logic [INDEX_W-1:0] obj,
                                 input logic [PRIO_W-1:0] prio,
                                 input logic [LEVEL_W-1:0] lvl);
         pending_responses.push_back(resolve_command(op, obj, prio, lvl));
      endfunction

      function void check_response(input response_type got);
         response_type want;
         if (pending_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: response with no command waiting: %p", $realtime, got);
            end
         end else begin
            want = pending_responses.pop_front();
            responses_checked++;
            status_counts[want.status]++;
            if (got.status != want.status || got.present_value != want.present_value ||
                got.active_priority != want.active_priority ||
                got.slot_level != want.slot_level || got.slot_null != want.slot_null) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: response mismatch, expected %p, got %p",
                           $realtime, want, got);
               end
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   cpa_req_if req_bus ();
   cpa_rsp_if rsp_bus ();
   cpa_csr_if csr_bus ();

   priority_array_scoreboard board = new();

   bit req_gaps_on;
   bit rsp_stalls_on;
   int hold_request;
   int commands_sent;
   int default_writes;

   command_priority_array dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Clock: 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offers one command item and returns at the edge that accepts it.
   task automatic send_command(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] obj,
                               input logic [PRIO_W-1:0] prio,
                               input logic [LEVEL_W-1:0] lvl);
      int gap;
      bit taken;
      gap = req_gaps_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.object_id <= obj;
      req_bus.priority_req <= prio;
      req_bus.level <= lvl;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
      board.note_command(op, obj, prio, lvl);
      commands_sent++;
   endtask

   // Writes the relinquish default; only called while the block is idle.
   task automatic write_default(input logic [PV_W-1:0] value);
      bit taken;
      csr_bus.valid <= 1'b1;
      csr_bus.relinquish_default <= value;
      do begin
         @(negedge clock);
         taken = csr_bus.ready;
         @(posedge clock);
      end while (!taken);
      csr_bus.valid <= 1'b0;
      board.set_default(value);
      default_writes++;
   endtask

   // Lowers the request valid, then waits for every response and a DRAIN_CYCLES settling time.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed commands on a few objects so the masks fill up;
   // the rest is noise over the whole width of every field.
   task automatic run_random(input int count, input int hold_at);
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] obj;
      logic [PRIO_W-1:0]  prio;
      logic [LEVEL_W-1:0] lvl;
      int                 pick;
      for (int n = 0; n < count; n++) begin
         if (n == hold_at) begin
            hold_request = 80;
         end
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            op = OP_W'($urandom);
            obj = INDEX_W'($urandom);
            prio = PRIO_W'($urandom);
            lvl = LEVEL_W'($urandom);
         end else begin
            if (pick < 50) begin
               op = OP_WRITE;
            end else if (pick < 72) begin
               op = OP_RELINQUISH;
            end else begin
               op = OP_READ;
            end
            obj = ($urandom_range(0, 99) < 60) ? INDEX_W'($urandom_range(0, 1))
                                                 : INDEX_W'($urandom_range(0, NUM_OBJECTS - 1));
            prio = PRIO_W'($urandom_range(1, NUM_PRIORITIES));
            lvl = ($urandom_range(0, 99) < 92) ? LEVEL_W'($urandom_range(0, MAX_LEVEL))
                                                 : LEVEL_W'($urandom_range(MAX_LEVEL + 1, 255));
         end
         send_command(op, obj, prio, lvl);
      end
   endtask

   // Response side: random stalls, and one long hold-off when asked.
   initial begin
      response_type got;
      int           stall;
      bit           taken;
      rsp_bus.ready <= 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end else begin
            stall = rsp_stalls_on ? $urandom_range(0, 12) : 0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do begin
            @(negedge clock);
            taken = rsp_bus.valid;
            got.status = rsp_bus.status;
            got.present_value = rsp_bus.present_value;
            got.active_priority = rsp_bus.active_priority;
            got.slot_level = rsp_bus.slot_level;
            got.slot_null = rsp_bus.slot_null;
            @(posedge clock);
         end while (!taken);
         board.check_response(got);
      end
   end

   // Main sequence.
   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.operation <= OP_WRITE;
      req_bus.object_id <= '0;
      req_bus.priority_req <= '0;
      req_bus.level <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.relinquish_default <= '0;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      hold_request = 0;
      commands_sent = 0;
      default_writes = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed commands with the reset default of zero.
      send_command(OP_READ, 8'd0, 5'd1, 8'd0);
      send_command(OP_WRITE, 8'd0, 5'd16, 8'd0);
      send_command(OP_WRITE, 8'd0, 5'd1, 8'd100);
      send_command(OP_READ, 8'd0, 5'd1, 8'd0);
      send_command(OP_READ, 8'd0, 5'd16, 8'd255);
      send_command(OP_WRITE, 8'd0, 5'd6, 8'd50);
      send_command(OP_RELINQUISH, 8'd0, 5'd6, 8'd0);
      send_command(OP_WRITE, 8'd0, 5'd0, 8'd10);
      send_command(OP_WRITE, 8'd0, 5'd17, 8'd10);
      send_command(OP_WRITE, 8'd0, 5'd31, 8'd255);
      send_command(OP_WRITE, 8'd0, 5'd3, 8'd101);
      send_command(OP_WRITE, 8'd0, 5'd3, 8'd255);
      send_command(OP_RELINQUISH, 8'd0, 5'd0, 8'd0);
      send_command(OP_RELINQUISH, 8'd0, 5'd31, 8'd0);
      send_command(OP_READ, 8'd0, 5'd0, 8'd0);
      send_command(OP_READ, 8'd0, 5'd17, 8'd0);
      send_command(OP_READ, 8'd0, 5'd31, 8'd0);
      send_command(OP_UNUSED, 8'd0, 5'd2, 8'd20);
      send_command(OP_WRITE, 8'd8, 5'd2, 8'd40);
      send_command(OP_READ, 8'd255, 5'd1, 8'd0);
      send_command(OP_RELINQUISH, 8'd0, 5'd1, 8'd0);
      send_command(OP_RELINQUISH, 8'd0, 5'd16, 8'd0);
      send_command(OP_READ, 8'd7, 5'd6, 8'd0);
      send_command(OP_WRITE, 8'd7, 5'd2, 8'd55);
      send_command(OP_READ, 8'd7, 5'd2, 8'd0);
      drain();

      // Default above 100 reads back as 100; both sides idle at random.
      write_default(7'd127);
      run_random(110, -1);
      drain();

      // Default at the top of the range; no idling, one long response hold-off.
      write_default(7'd100);
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      run_random(110, 20);
      drain();

      // Random default; only the request side idles.
      write_default(PV_W'($urandom_range(0, 127)));
      req_gaps_on = 1'b1;
      run_random(110, -1);
      drain();

      // Default of zero; only the response side stalls.
      write_default(7'd0);
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b1;
      run_random(110, -1);
      drain();

      $display("Covered %0d commands and %0d responses under %0d default settings.",
               commands_sent, board.responses_checked, default_writes);
      $display("Statuses: ok %0d, unknown %0d, denied %0d, range %0d, index %0d.",
               board.status_counts[ST_OK], board.status_counts[ST_UNKNOWN_OBJECT],
               board.status_counts[ST_ACCESS_DENIED], board.status_counts[ST_OUT_OF_RANGE],
               board.status_counts[ST_BAD_INDEX]);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule
